// ===== rtl/core/ntft_pkg.sv =====
package ntft_pkg;

  typedef logic [63:0] stamp_t;
  typedef logic [15:0] tag_t;
  typedef logic [5:0]  index_t;
  typedef logic [6:0]  count_t;
  typedef logic [1:0]  code_t;

  // Request actions
  localparam code_t ACT_APPEND = 2'd0;
  localparam code_t ACT_LOOKUP = 2'd1;
  localparam code_t ACT_FLUSH  = 2'd2;
  localparam code_t ACT_NOP    = 2'd3;

  // Result status codes
  localparam code_t RS_OK        = 2'd0;
  localparam code_t RS_NOT_NEWER = 2'd1;
  localparam code_t RS_FULL      = 2'd2;
  localparam code_t RS_MISS      = 2'd3;

  // Reported bound of an empty table
  localparam stamp_t NO_STAMP = '1;

  typedef struct packed {
    code_t  action;
    stamp_t timestamp;
    tag_t   frame_tag;
  } request_t;

  typedef struct packed {
    code_t  status;
    tag_t   found_tag;
    index_t found_index;
    logic   in_span;
    stamp_t first_stamp;
    stamp_t last_stamp;
    count_t entry_count;
  } result_t;

  // Classified operation handed from the front queue to the table engine
  typedef struct packed {
    logic   append;
    logic   lookup;
    logic   flush;
    stamp_t stamp;
    tag_t   tag;
  } op_t;

endpackage

// ===== rtl/core/nearest_timestamp_frame_table.sv =====
// Channel   Ports                  Accepted when        Carries
// -------   ---------------------  -------------------  -------------------------------
// request   push, full, request    push && !full        action, timestamp, frame_tag
// result    empty, pop, result     pop && !empty        status, tag, index, span, bounds
//
// Append, flush and the unused action complete in the table engine without a scan. A
// lookup inside the stored span scans the table memory through its single read port, one
// entry per cycle, up to the first entry not below the timestamp, then picks the nearer
// neighbour unless that entry matches exactly. A lookup outside the span does not scan.
// Reset (rst, synchronous) empties the table and both queues; no clearing pass.
// A two-entry request queue keeps accepting, until it fills, while a result waits to be popped.
module nearest_timestamp_frame_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ntft_pkg::request_t request,
  output logic               empty,
  input  logic               pop,
  output ntft_pkg::result_t  result
);

  // Classified operation passed from the front queue to the table engine
  logic          op_valid;
  logic          take;
  ntft_pkg::op_t op;

  // Front: accept requests, decode the action, hold them until the engine is free
  ntft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .take     (take),
    .op_valid (op_valid),
    .op       (op)
  );

  // Back: own the table, run appends, flushes and scanning lookups, and hold
  // the finished result until it is popped
  ntft_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .take     (take),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== rtl/core/ntft_front.sv =====
module ntft_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ntft_pkg::request_t request,
  input  logic              take,
  output logic              op_valid,
  output ntft_pkg::op_t     op
);

  ntft_pkg::op_t slots [2];
  ntft_pkg::op_t op_in;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          accept;
  logic          drain;

  // Decode the action into one-hot operation flags; an unused action becomes no flag.
  always_comb begin
    op_in.append = 1'b0;
    op_in.lookup = 1'b0;
    op_in.flush  = 1'b0;
    op_in.stamp  = request.timestamp;
    op_in.tag    = request.frame_tag;
    unique case (request.action)
      ntft_pkg::ACT_APPEND: op_in.append = 1'b1;
      ntft_pkg::ACT_LOOKUP: op_in.lookup = 1'b1;
      ntft_pkg::ACT_FLUSH:  op_in.flush  = 1'b1;
      ntft_pkg::ACT_NOP:    op_in.append = 1'b0;
      default:              op_in.append = 1'b0;
    endcase
  end

  assign full     = (fill == 2'd2);
  assign op_valid = (fill != 2'd0);
  assign op       = slots[rd_ptr];
  assign accept   = push && !full;
  assign drain    = take && op_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (drain) begin
        rd_ptr <= !rd_ptr;
      end
      case ({accept, drain})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= op_in;
    end
  end

endmodule

// ===== rtl/core/ntft_back.sv =====
module ntft_back #(
  parameter int TABLE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  ntft_pkg::op_t     op,
  output logic              take,
  output logic              empty,
  input  logic              pop,
  output ntft_pkg::result_t result
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int TAG_W = (TAG_BITS < 16) ? TAG_BITS : 16;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  ntft_pkg::stamp_t stamp_mem [TABLE_DEPTH];
  logic [TAG_W-1:0] tag_mem   [TABLE_DEPTH];

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  ntft_pkg::stamp_t first_stamp;
  ntft_pkg::stamp_t last_stamp;
  logic             res_valid;
  ntft_pkg::result_t res;

  ntft_pkg::stamp_t ts;
  logic [IDX_W-1:0] scan_idx;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  ntft_pkg::stamp_t rd_stamp;
  logic [TAG_W-1:0] rd_tag;
  ntft_pkg::stamp_t prev_stamp;
  logic [TAG_W-1:0] prev_tag;
  ntft_pkg::stamp_t dlo;
  ntft_pkg::stamp_t dhi;
  logic [IDX_W-1:0] hi_idx;
  logic [TAG_W-1:0] hi_tag;

  logic             start;
  logic             last_lt;
  logic             not_newer;
  logic             is_full;
  logic             app_ok;
  logic             span;
  logic             do_scan;
  logic             hit;
  logic             exact;
  logic             pick_lo;
  ntft_pkg::stamp_t first_after;
  ntft_pkg::stamp_t last_after;
  logic [CNT_W-1:0] count_after;
  ntft_pkg::result_t res_start;

  always_comb begin
    start     = (state == ST_IDLE) && op_valid && (!res_valid || pop);
    last_lt   = $signed(last_stamp) < $signed(op.stamp);
    not_newer = (count != '0) && !last_lt;
    is_full   = (count >= CNT_W'(TABLE_DEPTH));
    app_ok    = op.append && !not_newer && !is_full;

    first_after = first_stamp;
    last_after  = last_stamp;
    count_after = count;
    if (op.flush) begin
      first_after = ntft_pkg::NO_STAMP;
      last_after  = ntft_pkg::NO_STAMP;
      count_after = '0;
    end else if (app_ok) begin
      if (count == '0) begin
        first_after = op.stamp;
      end
      last_after  = op.stamp;
      count_after = count + 1'b1;
    end

    span    = !($signed(op.stamp) < $signed(first_after)) &&
              !($signed(last_after) < $signed(op.stamp));
    do_scan = op.lookup && (count != '0) && span;

    res_start.status = ntft_pkg::RS_OK;
    if (op.append) begin
      if (not_newer) begin
        res_start.status = ntft_pkg::RS_NOT_NEWER;
      end else if (is_full) begin
        res_start.status = ntft_pkg::RS_FULL;
      end
    end else if (op.lookup) begin
      res_start.status = ntft_pkg::RS_MISS;
    end
    res_start.found_tag   = '0;
    res_start.found_index = '0;
    res_start.in_span     = span;
    res_start.first_stamp = first_after;
    res_start.last_stamp  = last_after;
    res_start.entry_count = ntft_pkg::count_t'(count_after);

    hit     = rd_valid && !($signed(rd_stamp) < $signed(ts));
    exact   = (rd_stamp == ts);
    pick_lo = (dlo < dhi);
  end

  assign take   = start;
  assign empty  = !res_valid;
  assign result = res;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      first_stamp <= ntft_pkg::NO_STAMP;
      last_stamp  <= ntft_pkg::NO_STAMP;
      res_valid   <= 1'b0;
      rd_valid    <= 1'b0;
      scan_idx    <= '0;
    end else begin
      rd_valid <= (state == ST_SCAN) && !hit;
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            first_stamp <= first_after;
            last_stamp  <= last_after;
            count       <= count_after;
            scan_idx    <= '0;
            if (do_scan) begin
              state <= ST_SCAN;
            end else begin
              res_valid <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (hit) begin
            if (exact) begin
              res_valid <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              state <= ST_PICK;
            end
          end
        end
        ST_PICK: begin
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Table storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (start && app_ok) begin
      stamp_mem[count[IDX_W-1:0]] <= op.stamp;
      tag_mem[count[IDX_W-1:0]]   <= op.tag[TAG_W-1:0];
    end
    if (state == ST_SCAN) begin
      rd_stamp <= stamp_mem[scan_idx];
      rd_tag   <= tag_mem[scan_idx];
    end
  end

  // Scan datapath and result payload
  always_ff @(posedge clk) begin
    if (start) begin
      res <= res_start;
      ts  <= op.stamp;
    end
    if (state == ST_SCAN) begin
      rd_idx <= scan_idx;
      if (rd_valid && !hit) begin
        prev_stamp <= rd_stamp;
        prev_tag   <= rd_tag;
      end
      if (hit) begin
        dlo    <= ts - prev_stamp;
        dhi    <= rd_stamp - ts;
        hi_idx <= rd_idx;
        hi_tag <= rd_tag;
        if (exact) begin
          res.status      <= ntft_pkg::RS_OK;
          res.found_tag   <= ntft_pkg::tag_t'(rd_tag);
          res.found_index <= ntft_pkg::index_t'(rd_idx);
        end
      end
    end
    if (state == ST_PICK) begin
      res.status <= ntft_pkg::RS_OK;
      if (pick_lo) begin
        res.found_tag   <= ntft_pkg::tag_t'(prev_tag);
        res.found_index <= ntft_pkg::index_t'(hi_idx - 1'b1);
      end else begin
        res.found_tag   <= ntft_pkg::tag_t'(hi_tag);
        res.found_index <= ntft_pkg::index_t'(hi_idx);
      end
    end
  end

endmodule

// ===== rtl/core/ntft_checker.sv =====
module ntft_assertions #(
  parameter int TABLE_DEPTH = 64
) (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input ntft_pkg::result_t result
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // Hold a waiting result until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  // A step that ends with a failing status reports no match
  a_no_match: assert property (@(posedge clk) disable iff (rst)
    !empty && result.status != ntft_pkg::RS_OK |->
      result.found_tag == '0 && result.found_index == '0)
    else $error("match fields set without a match");

  // Stored bounds stay ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> $signed(result.first_stamp) <= $signed(result.last_stamp))
    else $error("first stamp above last stamp");

  // An empty table reports both bounds as minus one
  a_empty_bounds: assert property (@(posedge clk) disable iff (rst)
    !empty && (TABLE_DEPTH < 128) && result.entry_count == '0 |->
      result.first_stamp == ntft_pkg::NO_STAMP && result.last_stamp == ntft_pkg::NO_STAMP)
    else $error("empty table with stored bounds");

endmodule

bind nearest_timestamp_frame_table ntft_assertions #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);
